>>> rtl/lcdws_pkg.sv
package lcdws_pkg;

    // Sequencer modes, one-hot
    typedef enum logic [5:0] {
        M_INIT1 = 6'b000001,
        M_INIT2 = 6'b000010,
        M_INIT3 = 6'b000100,
        M_IDLE  = 6'b001000,
        M_WADDR = 6'b010000,
        M_WCHAR = 6'b100000
    } t_mode;

    // Tick phases of one bus command
    localparam logic [1:0] PH_SETUP = 2'd0;
    localparam logic [1:0] PH_RISE  = 2'd1;
    localparam logic [1:0] PH_FALL  = 2'd2;

    // Input kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_FUNC_SET  = 2'd0;
    localparam logic [1:0] CFG_DISP_CTRL = 2'd1;
    localparam logic [1:0] CFG_ENTRY     = 2'd2;

    // Reset values of the init command bytes
    localparam logic [7:0] FUNC_SET_RST  = 8'h3F;
    localparam logic [7:0] DISP_CTRL_RST = 8'h0C;
    localparam logic [7:0] ENTRY_RST     = 8'h06;

    // Set-DDRAM-address command bit
    localparam logic [7:0] ADDR_CMD = 8'h80;

    typedef struct packed {
        logic [7:0] func_set;
        logic [7:0] disp_ctrl;
        logic [7:0] entry;
    } t_cfg;

    typedef struct packed {
        logic [7:0] bus_data;
        logic       reg_select;
        logic       enable_strobe;
        logic       ready_res;
        logic       accepted;
    } t_result;

endpackage

>>> rtl/lcdws_cfg.sv
module lcdws_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output lcdws_pkg::t_cfg   o_cfg
);
    import lcdws_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FUNC_SET:  n_cfg.func_set  = i_cfg_data;
                CFG_DISP_CTRL: n_cfg.disp_ctrl = i_cfg_data;
                CFG_ENTRY:     n_cfg.entry     = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.func_set  <= FUNC_SET_RST;
            r_cfg.disp_ctrl <= DISP_CTRL_RST;
            r_cfg.entry     <= ENTRY_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/lcdws_core.sv
module lcdws_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_kind,
    input  logic [7:0]          i_character,
    input  logic [5:0]          i_column,
    input  logic [1:0]          i_row,
    input  lcdws_pkg::t_cfg     i_cfg,
    output lcdws_pkg::t_result  o_result
);
    import lcdws_pkg::*;

    t_mode      r_mode,    n_mode;
    logic [1:0] r_phase,   n_phase;
    logic [7:0] r_pending, n_pending;
    logic [7:0] r_data,    n_data;
    logic       r_select,  n_select;
    logic       r_enable,  n_enable;
    logic       took;

    // Next bus and sequencer state for one tick or write request
    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_pending = r_pending;
        n_data    = r_data;
        n_select  = r_select;
        n_enable  = r_enable;
        took      = 1'b0;
        if (i_kind == KIND_TICK) begin
            case (r_phase)
                PH_SETUP: begin
                    case (r_mode)
                        M_WCHAR: begin
                            n_data    = r_pending;
                            n_select  = 1'b1;
                            n_pending = 8'd0;
                        end
                        M_INIT2: begin
                            n_data   = i_cfg.disp_ctrl;
                            n_select = 1'b0;
                        end
                        M_INIT3: begin
                            n_data   = i_cfg.entry;
                            n_select = 1'b0;
                        end
                        default: n_data = r_data;
                    endcase
                    if (r_mode != M_IDLE) begin
                        n_phase = PH_RISE;
                    end
                end
                PH_RISE: begin
                    // Reload function set so a late config write takes effect
                    if (r_mode == M_INIT1) begin
                        n_data   = i_cfg.func_set;
                        n_select = 1'b0;
                    end
                    n_enable = 1'b1;
                    n_phase  = PH_FALL;
                end
                PH_FALL: begin
                    n_enable = 1'b0;
                    n_phase  = PH_SETUP;
                    case (r_mode)
                        M_INIT1: n_mode = M_INIT2;
                        M_INIT2: n_mode = M_INIT3;
                        M_INIT3: n_mode = M_IDLE;
                        M_WADDR: n_mode = M_WCHAR;
                        M_WCHAR: n_mode = M_IDLE;
                        default: n_mode = r_mode;
                    endcase
                end
                default: n_phase = PH_SETUP;
            endcase
        end else if (r_mode == M_IDLE && r_phase == PH_SETUP) begin
            // Take the request and drive set-address at once
            n_pending = i_character;
            n_data    = ADDR_CMD | {i_row, i_column};
            n_select  = 1'b0;
            n_mode    = M_WADDR;
            took      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_INIT1;
            r_phase   <= PH_RISE;
            r_pending <= 8'd0;
            r_data    <= FUNC_SET_RST;
            r_select  <= 1'b0;
            r_enable  <= 1'b0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_data    <= n_data;
            r_select  <= n_select;
            r_enable  <= n_enable;
        end
    end

    // Result shows the state after this item
    always_comb begin
        o_result.bus_data      = n_data;
        o_result.reg_select    = n_select;
        o_result.enable_strobe = n_enable;
        o_result.ready_res     = (n_mode == M_IDLE) && (n_phase == PH_SETUP);
        o_result.accepted      = took;
    end

endmodule

>>> rtl/lcdws_out.sv
module lcdws_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  lcdws_pkg::t_result  i_result,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_in_ready,
    output lcdws_pkg::t_result  o_result
);
    import lcdws_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Take a new request when empty or when the held result leaves this cycle
    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

>>> rtl/char_lcd_write_sequencer.sv
// Character LCD write sequencer for an 8-bit parallel bus.
// Input channel (i_in_valid / o_in_ready): each request is either a timer
// tick (i_kind = 0) or a write-character request (i_kind = 1) with
// character, column and row. Every request gives exactly one result on the
// output channel (o_out_valid / i_out_ready): the bus byte, register select,
// enable level, the ready flag and whether a write request was taken.
// A command needs three ticks: bus setup, enable rise, enable fall.
// Results are registered and shown in the cycle after the request is taken.
// One request per cycle is sustained while the receiver does not stall.
// Reset starts the init sequence (function set, display control, entry
// mode) in its enable-rise phase; the output register is empty.
// When the receiver stalls, the result is held in the output register and
// o_in_ready drops until it is taken; it rises again in the same cycle the
// result leaves.
// Configuration (i_cfg_valid / o_cfg_ready) writes the three init command
// bytes by index and is always ready; an unknown index is ignored.
module char_lcd_write_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_character,
    input  logic [5:0] i_column,
    input  logic [1:0] i_row,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_bus_data,
    output logic       o_reg_select,
    output logic       o_enable_strobe,
    output logic       o_ready_res,
    output logic       o_accepted,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import lcdws_pkg::*;

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    fire;

    assign o_cfg_ready = 1'b1;
    assign fire        = i_in_valid && o_in_ready;

    lcdws_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lcdws_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_kind      (i_kind),
        .i_character (i_character),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_cfg       (cfg),
        .o_result    (core_result)
    );

    lcdws_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_result    (core_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_in_ready  (o_in_ready),
        .o_result    (out_result)
    );

    assign o_bus_data      = out_result.bus_data;
    assign o_reg_select    = out_result.reg_select;
    assign o_enable_strobe = out_result.enable_strobe;
    assign o_ready_res     = out_result.ready_res;
    assign o_accepted      = out_result.accepted;

endmodule

>>> rtl/lcdws_checker.sv
module lcdws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_bus_data,
    input logic       o_reg_select,
    input logic       o_enable_strobe,
    input logic       o_ready_res,
    input logic       o_accepted
);

    // A taken write leaves the block busy with set-address on the bus
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> !o_ready_res && !o_reg_select && o_bus_data[7])
        else $error("taken write did not drive set-address");

    // Enable is never high while idle
    a_idle_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_enable_strobe |-> !o_ready_res)
        else $error("enable high while idle");

    // A stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while result stalled");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bus_data)
            && $stable(o_accepted))
        else $error("stalled result changed");

endmodule

bind char_lcd_write_sequencer lcdws_checker u_lcdws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_bus_data      (o_bus_data),
    .o_reg_select    (o_reg_select),
    .o_enable_strobe (o_enable_strobe),
    .o_ready_res     (o_ready_res),
    .o_accepted      (o_accepted)
);
